@@ rtl/bcrs_pkg.sv @@
// Shared types and constants for the best chi2 rotation selector.
package bcrs_pkg;

	// Configuration register indexes.
	typedef enum logic [3:0] {
		REG_ETA_CENTER      = 4'd0,
		REG_ETA_INV_SIGMA   = 4'd1,
		REG_PI0_CENTER      = 4'd2,
		REG_PI0_INV_SIGMA   = 4'd3,
		REG_ETA_WINDOW_LOW  = 4'd4,
		REG_ETA_WINDOW_HIGH = 4'd5,
		REG_PI0_WINDOW_LOW  = 4'd6,
		REG_PI0_WINDOW_HIGH = 4'd7
	} cfg_idx_t;

	localparam int CFG_IDX_W = 4;
	localparam int SIGMA_W   = 16;
	localparam int RST_W     = 18;
	localparam int SCORE_W   = 32;
	localparam int SAT_W     = 16;

	localparam logic [RST_W-1:0]   ETA_CENTER_RST      = 18'd35848;
	localparam logic [SIGMA_W-1:0] ETA_INV_SIGMA_RST   = 16'd5120;
	localparam logic [RST_W-1:0]   PI0_CENTER_RST      = 18'd8847;
	localparam logic [SIGMA_W-1:0] PI0_INV_SIGMA_RST   = 16'd25600;
	localparam logic [RST_W-1:0]   ETA_WINDOW_LOW_RST  = 18'd32768;
	localparam logic [RST_W-1:0]   ETA_WINDOW_HIGH_RST = 18'd39322;
	localparam logic [RST_W-1:0]   PI0_WINDOW_LOW_RST  = 18'd8192;
	localparam logic [RST_W-1:0]   PI0_WINDOW_HIGH_RST = 18'd9503;

	// Saturation limits of a scaled deviation magnitude.
	localparam logic [SAT_W-1:0] SAT_POS = 16'd32767;
	localparam logic [SAT_W-1:0] SAT_NEG = 16'd32768;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DEV_ETA,
		ST_DEV_PI0,
		ST_SQ_ETA,
		ST_SQ_PI0,
		ST_SUM
	} bcrs_state_t;

endpackage

@@ rtl/bcrs_if.sv @@
// Handshake interfaces for candidate rows, event results and configuration writes.
interface bcrs_row_if #(parameter int MASS_BITS = 18);
	logic                 valid;
	logic                 ready;
	logic [MASS_BITS-1:0] lepton_photon_mass;
	logic [MASS_BITS-1:0] photon_pair_mass;
	logic [MASS_BITS-1:0] full_mass;
	modport source (output valid, lepton_photon_mass, photon_pair_mass, full_mass,
		input ready);
	modport sink (input valid, lepton_photon_mass, photon_pair_mass, full_mass,
		output ready);
endinterface

interface bcrs_res_if #(parameter int MASS_BITS = 18);
	logic                 valid;
	logic                 ready;
	logic [MASS_BITS-1:0] chosen_full_mass;
	logic                 keep;
	modport source (output valid, chosen_full_mass, keep, input ready);
	modport sink (input valid, chosen_full_mass, keep, output ready);
endinterface

interface bcrs_cfg_if #(parameter int DATA_W = 18);
	logic                           valid;
	logic                           ready;
	logic [bcrs_pkg::CFG_IDX_W-1:0] index;
	logic [DATA_W-1:0]              data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/bcrs_mul_unit.sv @@
// Shared multiplier with a registered product.
module bcrs_mul_unit #(
	parameter int A_W = 18
) (
	input  logic                              clk,
	input  logic [A_W-1:0]                    a,
	input  logic [bcrs_pkg::SIGMA_W-1:0]      b,
	output logic [A_W+bcrs_pkg::SIGMA_W-1:0]  prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

endmodule

@@ rtl/bcrs_cfg_regs.sv @@
// Configuration register file for centers, inverse sigmas and mass windows.
module bcrs_cfg_regs #(
	parameter int MASS_BITS = 18,
	parameter int REG_W     = 18
) (
	input  logic                          clk,
	input  logic                          arst_n,
	bcrs_cfg_if.sink                      cfg,
	output logic [REG_W-1:0]              eta_center_q,
	output logic [bcrs_pkg::SIGMA_W-1:0]  eta_inv_sigma_q,
	output logic [REG_W-1:0]              pi0_center_q,
	output logic [bcrs_pkg::SIGMA_W-1:0]  pi0_inv_sigma_q,
	output logic [REG_W-1:0]              eta_window_low_q,
	output logic [REG_W-1:0]              eta_window_high_q,
	output logic [REG_W-1:0]              pi0_window_low_q,
	output logic [REG_W-1:0]              pi0_window_high_q
);

	logic [REG_W-1:0]             mass_val;
	logic [bcrs_pkg::SIGMA_W-1:0] sigma_val;

	assign cfg.ready = 1'b1;
	// Bits above the field width are dropped.
	assign mass_val  = REG_W'(cfg.data[MASS_BITS-1:0]);
	assign sigma_val = cfg.data[bcrs_pkg::SIGMA_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eta_center_q      <= REG_W'(bcrs_pkg::ETA_CENTER_RST);
			eta_inv_sigma_q   <= bcrs_pkg::ETA_INV_SIGMA_RST;
			pi0_center_q      <= REG_W'(bcrs_pkg::PI0_CENTER_RST);
			pi0_inv_sigma_q   <= bcrs_pkg::PI0_INV_SIGMA_RST;
			eta_window_low_q  <= REG_W'(bcrs_pkg::ETA_WINDOW_LOW_RST);
			eta_window_high_q <= REG_W'(bcrs_pkg::ETA_WINDOW_HIGH_RST);
			pi0_window_low_q  <= REG_W'(bcrs_pkg::PI0_WINDOW_LOW_RST);
			pi0_window_high_q <= REG_W'(bcrs_pkg::PI0_WINDOW_HIGH_RST);
		end else if (cfg.valid) begin
			case (cfg.index)
				bcrs_pkg::REG_ETA_CENTER:      eta_center_q      <= mass_val;
				bcrs_pkg::REG_ETA_INV_SIGMA:   eta_inv_sigma_q   <= sigma_val;
				bcrs_pkg::REG_PI0_CENTER:      pi0_center_q      <= mass_val;
				bcrs_pkg::REG_PI0_INV_SIGMA:   pi0_inv_sigma_q   <= sigma_val;
				bcrs_pkg::REG_ETA_WINDOW_LOW:  eta_window_low_q  <= mass_val;
				bcrs_pkg::REG_ETA_WINDOW_HIGH: eta_window_high_q <= mass_val;
				bcrs_pkg::REG_PI0_WINDOW_LOW:  pi0_window_low_q  <= mass_val;
				bcrs_pkg::REG_PI0_WINDOW_HIGH: pi0_window_high_q <= mass_val;
				default: ;
			endcase
		end
	end

endmodule

@@ rtl/best_chi2_rotation_selector_unit.sv @@
// A row request is accepted in idle and then passes the five states of the multiplier sequencer.
// A new row is accepted only after the previous one leaves the sequencer, as the four products share one multiplier.
// The event result is registered on the last row and waits there until taken,
// while the next row is already accepted; a new result only stalls if the old one is unread.
// Reset (arst_n low, asynchronous) restores the register defaults and drops a partial event.
module best_chi2_rotation_selector_unit #(
	parameter int ROTATIONS = 3,
	parameter int MASS_BITS = 18
) (
	input  logic       clk,
	input  logic       arst_n,
	bcrs_row_if.sink   rows,
	bcrs_res_if.source results,
	bcrs_cfg_if.sink   cfg
);

	// Registers keep at least the width of their reset values.
	localparam int REG_W  = (MASS_BITS > bcrs_pkg::RST_W) ? MASS_BITS : bcrs_pkg::RST_W;
	localparam int PROD_W = REG_W + bcrs_pkg::SIGMA_W;
	localparam int ROT_W  = $clog2(ROTATIONS);
	localparam int SW     = bcrs_pkg::SAT_W;
	localparam logic [ROT_W-1:0] ROT_LAST = ROT_W'(ROTATIONS - 1);

	// Configuration registers.
	logic [REG_W-1:0]             eta_center, pi0_center;
	logic [bcrs_pkg::SIGMA_W-1:0] eta_inv_sigma, pi0_inv_sigma;
	logic [REG_W-1:0]             eta_win_lo, eta_win_hi, pi0_win_lo, pi0_win_hi;

	bcrs_cfg_regs #(
		.MASS_BITS (MASS_BITS),
		.REG_W     (REG_W)
	) u_cfg (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg               (cfg),
		.eta_center_q      (eta_center),
		.eta_inv_sigma_q   (eta_inv_sigma),
		.pi0_center_q      (pi0_center),
		.pi0_inv_sigma_q   (pi0_inv_sigma),
		.eta_window_low_q  (eta_win_lo),
		.eta_window_high_q (eta_win_hi),
		.pi0_window_low_q  (pi0_win_lo),
		.pi0_window_high_q (pi0_win_hi)
	);

	bcrs_pkg::bcrs_state_t state_q, state_d;

	// The row being scored.
	logic [MASS_BITS-1:0] lg_q, gg_q, full_q;
	logic                 neg_eta_q, neg_pi0_q;
	logic [SW-1:0]        se_q, sp_q;
	logic [bcrs_pkg::SCORE_W-1:0] acc_q;

	// Per-event state.
	logic [ROT_W-1:0]             rot_q;
	logic [bcrs_pkg::SCORE_W-1:0] best_score_q;
	logic [MASS_BITS-1:0]         best_full_q, best_lg_q, best_gg_q;

	// Result register.
	logic                 out_valid_q;
	logic [MASS_BITS-1:0] out_full_q;
	logic                 out_keep_q;

	logic row_acc;
	assign row_acc = rows.valid && rows.ready;

	// Shared deviation subtractor: operands picked by the sequencer state.
	logic [REG_W-1:0] dev_m, dev_c, dev_mag;
	logic             dev_neg;
	logic             sel_pi0;

	assign dev_m   = sel_pi0 ? REG_W'(gg_q) : REG_W'(lg_q);
	assign dev_c   = sel_pi0 ? pi0_center : eta_center;
	assign dev_neg = dev_m < dev_c;
	assign dev_mag = dev_neg ? (dev_c - dev_m) : (dev_m - dev_c);

	// Shared multiplier: scaling in the deviation states, squaring afterwards.
	logic [REG_W-1:0]             mul_a;
	logic [bcrs_pkg::SIGMA_W-1:0] mul_b;
	logic [PROD_W-1:0]            prod_q;

	bcrs_mul_unit #(.A_W(REG_W)) u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	// Truncate the scaled product to 8 fraction bits and saturate to 16-bit signed.
	logic [REG_W-1:0] sh_mag;
	logic             sat_neg;
	logic [SW-1:0]    sat_mag;

	assign sh_mag  = prod_q[PROD_W-1:bcrs_pkg::SIGMA_W];
	assign sat_neg = (state_q == bcrs_pkg::ST_DEV_PI0) ? neg_eta_q : neg_pi0_q;
	always_comb begin
		if (sat_neg) begin
			sat_mag = (sh_mag > REG_W'(bcrs_pkg::SAT_NEG)) ? bcrs_pkg::SAT_NEG : sh_mag[SW-1:0];
		end else begin
			sat_mag = (sh_mag > REG_W'(bcrs_pkg::SAT_POS)) ? bcrs_pkg::SAT_POS : sh_mag[SW-1:0];
		end
	end

	// Score of the row and the selection against the best so far.
	logic [bcrs_pkg::SCORE_W-1:0] score;
	logic                         take, last, stall, evt_done;
	logic [MASS_BITS-1:0]         sel_full, sel_lg, sel_gg;
	logic                         keep;

	assign score    = acc_q + prod_q[bcrs_pkg::SCORE_W-1:0];
	assign take     = score < best_score_q;
	assign last     = rot_q >= ROT_LAST;
	assign stall    = last && out_valid_q && !results.ready;
	assign evt_done = (state_q == bcrs_pkg::ST_SUM) && !stall && last;
	assign sel_full = take ? full_q : best_full_q;
	assign sel_lg   = take ? lg_q : best_lg_q;
	assign sel_gg   = take ? gg_q : best_gg_q;
	assign keep     = (REG_W'(sel_lg) >= eta_win_lo) && (REG_W'(sel_lg) <= eta_win_hi) &&
		(REG_W'(sel_gg) >= pi0_win_lo) && (REG_W'(sel_gg) <= pi0_win_hi);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			bcrs_pkg::ST_IDLE:    if (row_acc) state_d = bcrs_pkg::ST_DEV_ETA;
			bcrs_pkg::ST_DEV_ETA: state_d = bcrs_pkg::ST_DEV_PI0;
			bcrs_pkg::ST_DEV_PI0: state_d = bcrs_pkg::ST_SQ_ETA;
			bcrs_pkg::ST_SQ_ETA:  state_d = bcrs_pkg::ST_SQ_PI0;
			bcrs_pkg::ST_SQ_PI0:  state_d = bcrs_pkg::ST_SUM;
			bcrs_pkg::ST_SUM:     if (!stall) state_d = bcrs_pkg::ST_IDLE;
			default:              state_d = bcrs_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs: ready and multiplier operand selection.
	always_comb begin
		rows.ready = 1'b0;
		sel_pi0    = 1'b0;
		mul_a      = dev_mag;
		mul_b      = eta_inv_sigma;
		case (state_q)
			bcrs_pkg::ST_IDLE: begin
				rows.ready = 1'b1;
			end
			bcrs_pkg::ST_DEV_ETA: begin
				mul_a = dev_mag;
				mul_b = eta_inv_sigma;
			end
			bcrs_pkg::ST_DEV_PI0: begin
				sel_pi0 = 1'b1;
				mul_a   = dev_mag;
				mul_b   = pi0_inv_sigma;
			end
			bcrs_pkg::ST_SQ_ETA: begin
				mul_a = REG_W'(se_q);
				mul_b = se_q;
			end
			// The pi0 square is kept in the product register for as long as the
			// scoring step waits on the result side.
			bcrs_pkg::ST_SQ_PI0, bcrs_pkg::ST_SUM: begin
				mul_a = REG_W'(sp_q);
				mul_b = sp_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bcrs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Row datapath registers.
	always_ff @(posedge clk) begin
		if (row_acc) begin
			lg_q   <= rows.lepton_photon_mass;
			gg_q   <= rows.photon_pair_mass;
			full_q <= rows.full_mass;
		end
		case (state_q)
			bcrs_pkg::ST_DEV_ETA: neg_eta_q <= dev_neg;
			bcrs_pkg::ST_DEV_PI0: begin
				neg_pi0_q <= dev_neg;
				se_q      <= sat_mag;
			end
			bcrs_pkg::ST_SQ_ETA: sp_q <= sat_mag;
			bcrs_pkg::ST_SQ_PI0: acc_q <= prod_q[bcrs_pkg::SCORE_W-1:0];
			default: ;
		endcase
	end

	// Event state and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q        <= '0;
			best_score_q <= '1;
			best_full_q  <= '0;
			best_lg_q    <= '0;
			best_gg_q    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			// A result closed in the same cycle as the old one is taken keeps valid high.
			if (evt_done) begin
				out_valid_q <= 1'b1;
			end else if (results.valid && results.ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == bcrs_pkg::ST_SUM && !stall) begin
				if (last) begin
					// Close the event and clear for the next one.
					rot_q        <= '0;
					best_score_q <= '1;
					best_full_q  <= '0;
					best_lg_q    <= '0;
					best_gg_q    <= '0;
				end else begin
					rot_q <= rot_q + 1'b1;
					if (take) begin
						best_score_q <= score;
						best_full_q  <= full_q;
						best_lg_q    <= lg_q;
						best_gg_q    <= gg_q;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (evt_done) begin
			out_full_q <= sel_full;
			out_keep_q <= keep;
		end
	end

	assign results.valid            = out_valid_q;
	assign results.chosen_full_mass = out_full_q;
	assign results.keep             = out_keep_q;

`ifndef SYNTH
	// An accepted row always starts the sequencer on the eta deviation.
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		row_acc |=> state_q == bcrs_pkg::ST_DEV_ETA)
		else $error("accepted row did not start the sequencer");

	// A new result can only appear out of the scoring step.
	a_result_from_sum: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == bcrs_pkg::ST_SUM)
		else $error("result appeared outside the scoring step");

	// A saturated eta term never exceeds the negative limit.
	a_sat_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bcrs_pkg::ST_SQ_ETA |-> se_q <= bcrs_pkg::SAT_NEG)
		else $error("scaled deviation out of saturation range");

	// The rotation counter stays inside the event.
	a_rot_range: assert property (@(posedge clk) disable iff (!arst_n)
		rot_q <= ROT_LAST)
		else $error("rotation index beyond last row");
`endif

endmodule
